// ----- hw/rtl/alid_pkg.sv -----
// Shared constants, types and codes for the array list insert/delete block.
package alid_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_WRVAL,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic [LEN_W-1:0]         list_length;
  } out_item_t;

endpackage

// ----- hw/rtl/alid_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module alid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/array_list_insert_delete_top.sv -----
// Top level of the array list insert/delete block: control, length count and element RAM.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o    | in_item_i  (cmd, position, value)
//  out     | output    | out_valid_o / out_ready_i  | out_item_o (status, removed_value,
//          |           |                            |             list_length)
//
// One item at a time. A rejected item (bad position, full list) goes straight to
// the response state. An insert steps through S_SHIFT, S_DRAIN, S_WRVAL and S_RESP
// (an append goes straight to S_WRVAL), a delete through S_SHIFT, S_DRAIN and S_RESP;
// the single RAM read and write port moves one element per cycle in S_SHIFT.
// Reset clears the length and the handshake state; RAM contents are left as is.
// The finished item sits in an output register; a stalled output holds only the
// final hand-off, the next item is taken as soon as the result is registered.
module array_list_insert_delete_top
  import alid_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]         count_q, count_d;
  cmd_e                     cmd_q, cmd_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [ADDR_W-1:0]        idx_q, idx_d;     // target element index (position - 1)
  logic [ADDR_W-1:0]        ptr_q, ptr_d;     // current read address of the shift
  logic [ADDR_W-1:0]        end_q, end_d;     // last read address of the shift
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;

  // read issued last cycle: where its data goes
  logic                     pend_q, pend_d;
  logic                     pend_wr_q, pend_wr_d;  // 0: capture as removed word
  logic [ADDR_W-1:0]        pend_addr_q, pend_addr_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // RAM port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // decode of the incoming item
  logic [CMP_W-1:0]  pos_c, cnt_c;
  logic              ins_bad, del_bad, is_full, append;
  logic [ADDR_W-1:0] idx_c, last_c;
  logic              accept, out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  assign pos_c   = CMP_W'(in_item_i.position);
  assign cnt_c   = CMP_W'(count_q);
  assign ins_bad = (pos_c == '0) || (pos_c > cnt_c + CMP_W'(1));
  assign del_bad = (pos_c == '0) || (pos_c > cnt_c);
  assign is_full = (count_q == CNT_W'(CAPACITY));
  assign append  = (cnt_c == pos_c - CMP_W'(1));
  assign idx_c   = ADDR_W'(pos_c - CMP_W'(1));
  assign last_c  = ADDR_W'(cnt_c - CMP_W'(1));

  alid_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.cmd == CMD_INSERT) begin
            if (ins_bad || is_full) begin
              state_d = S_RESP;
            end else if (append) begin
              state_d = S_WRVAL;
            end else begin
              state_d = S_SHIFT;
            end
          end else begin
            state_d = del_bad ? S_RESP : S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (ptr_q == end_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = (cmd_q == CMD_INSERT) ? S_WRVAL : S_RESP;
      S_WRVAL: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_d     = count_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    status_d    = status_q;
    removed_d   = removed_q;
    pend_d      = 1'b0;
    pend_wr_d   = pend_wr_q;
    pend_addr_d = pend_addr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;

    // data of last cycle's read: move it or keep it as the removed word
    if (pend_q) begin
      if (pend_wr_q) begin
        ram_we = 1'b1;
      end else begin
        removed_d = ram_rdata;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d     = in_item_i.cmd;
          val_d     = in_item_i.value;
          idx_d     = idx_c;
          removed_d = '0;
          status_d  = ST_DONE;
          if (in_item_i.cmd == CMD_INSERT) begin
            if (ins_bad) begin
              status_d = ST_RANGE;
            end else if (is_full) begin
              status_d = ST_FULL;
            end else begin
              ptr_d   = last_c;   // walk down from the tail
              end_d   = idx_c;
              count_d = count_q + CNT_W'(1);
            end
          end else begin
            if (del_bad) begin
              status_d = ST_RANGE;
            end else begin
              ptr_d   = idx_c;    // walk up from the removed slot
              end_d   = last_c;
              count_d = count_q - CNT_W'(1);
            end
          end
        end
      end
      S_SHIFT: begin
        ram_re = 1'b1;
        pend_d = 1'b1;
        if (cmd_q == CMD_INSERT) begin
          pend_wr_d   = 1'b1;
          pend_addr_d = ptr_q + ADDR_W'(1);
          ptr_d       = ptr_q - ADDR_W'(1);
        end else begin
          pend_wr_d   = (ptr_q != idx_q);
          pend_addr_d = ptr_q - ADDR_W'(1);
          ptr_d       = ptr_q + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        // pending move completes above
      end
      S_WRVAL: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = val_q;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = status_q;
          out_d.removed_value = removed_q;
          out_d.list_length   = LEN_W'(count_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    val_q       <= val_d;
    idx_q       <= idx_d;
    ptr_q       <= ptr_d;
    end_q       <= end_d;
    status_q    <= status_d;
    removed_q   <= removed_d;
    pend_wr_q   <= pend_wr_d;
    pend_addr_q <= pend_addr_d;
    out_q       <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
